// ===== src/ascm_pkg.sv =====
`default_nettype none

package ascm_pkg;

    localparam int SIZE_W    = 17;
    localparam int CLASS_W   = 8;
    localparam int BATCH_W   = 10;
    localparam int PAGE_W    = 5;
    localparam int QUOT_W    = 9;
    localparam int DIV_STEPS = QUOT_W;
    localparam int PROD_W    = BATCH_W + SIZE_W;
    localparam int PAGE_SHIFT = 12;

    localparam logic [SIZE_W-1:0] SIZE_LIMIT = 17'd65536;

    // Remainder seed for the divider: 65536 >> 9, which is below every divisor
    // for which the quotient is used.
    localparam logic [SIZE_W-1:0] DIV_SEED = 17'd128;

    // One word as it moves down the divider chain.
    typedef struct packed {
        logic [SIZE_W-1:0]  size;
        logic [CLASS_W-1:0] size_class;
        logic [SIZE_W-1:0]  rounded;
        logic [SIZE_W-1:0]  rem;
        logic [QUOT_W-1:0]  quot;
    } ascm_word_t;

endpackage

`default_nettype wire

// ===== src/ascm_div_step.sv =====
`default_nettype none

module ascm_div_step (
    input  wire                aclk,
    input  wire                aresetn,
    input  wire                en,
    input  wire                in_valid,
    input  wire ascm_pkg::ascm_word_t in_word,
    output logic               out_valid,
    output ascm_pkg::ascm_word_t out_word
);

    logic                        valid_reg;
    ascm_pkg::ascm_word_t        word_reg;
    ascm_pkg::ascm_word_t        word_next;
    logic [ascm_pkg::SIZE_W:0]   rem_shift;

    // One restoring step: shift the partial remainder, try the divisor.
    always_comb begin
        word_next = in_word;
        rem_shift = {in_word.rem, 1'b0};
        if (rem_shift >= {1'b0, in_word.size}) begin
            word_next.rem  = ascm_pkg::SIZE_W'(rem_shift - {1'b0, in_word.size});
            word_next.quot = {in_word.quot[ascm_pkg::QUOT_W-2:0], 1'b1};
        end else begin
            word_next.rem  = rem_shift[ascm_pkg::SIZE_W-1:0];
            word_next.quot = {in_word.quot[ascm_pkg::QUOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

endmodule

`default_nettype wire

// ===== src/alloc_size_class_mapper.sv =====
// Channel  | Direction | Handshake            | Payload
// s_       | in        | s_valid / s_ready    | s_byte_size
// m_       | out       | m_valid / m_ready    | m_size_class, m_rounded_size,
//          |           |                      | m_batch_count, m_page_count
//
// One word enters per cycle while the pipeline advances (see the stall rule below).
// The accepting edge loads the input register; the class stage, the nine-stage
// radix-2 divider that forms 65536 / size, and the batch and output registers follow.
// Reset is synchronous on aresetn low and clears only the valid bits.
// The whole pipeline advances together whenever the output register is empty or
// being taken, so a stall on m_ready holds every stage and loses nothing.
`default_nettype none

module alloc_size_class_mapper (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire  [16:0] s_byte_size,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [7:0]  m_size_class,
    output logic [16:0] m_rounded_size,
    output logic [9:0]  m_batch_count,
    output logic [4:0]  m_page_count
);

    localparam int SW = ascm_pkg::SIZE_W;
    localparam int CW = ascm_pkg::CLASS_W;
    localparam int BW = ascm_pkg::BATCH_W;
    localparam int PW = ascm_pkg::PAGE_W;
    localparam int QW = ascm_pkg::QUOT_W;
    localparam int NS = ascm_pkg::DIV_STEPS;
    localparam int FW = ascm_pkg::PROD_W - ascm_pkg::PAGE_SHIFT;

    logic en;

    // Input register, size saturated on the way in.
    logic          in_valid_reg;
    logic [SW-1:0] in_size_reg;

    // Class stage.
    logic                 cls_valid_reg;
    ascm_pkg::ascm_word_t cls_word_reg;
    ascm_pkg::ascm_word_t cls_word_next;

    // Divider chain.
    logic                 div_valid [0:NS];
    ascm_pkg::ascm_word_t div_word  [0:NS];

    // Batch stage.
    logic          bat_valid_reg;
    logic [SW-1:0] bat_size_reg;
    logic [CW-1:0] bat_class_reg;
    logic [SW-1:0] bat_rounded_reg;
    logic [BW-1:0] bat_batch_reg;
    logic [BW-1:0] bat_batch_next;

    // Output register.
    logic          out_valid_reg;
    logic [CW-1:0] out_class_reg;
    logic [SW-1:0] out_rounded_reg;
    logic [BW-1:0] out_batch_reg;
    logic [PW-1:0] out_pages_reg;
    logic [PW-1:0] out_pages_next;

    logic [ascm_pkg::PROD_W-1:0] prod;
    logic [FW-1:0]               pages_full;

    assign en      = !out_valid_reg || m_ready;
    assign s_ready = en;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            cls_valid_reg <= 1'b0;
            bat_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            in_valid_reg  <= s_valid;
            cls_valid_reg <= in_valid_reg;
            bat_valid_reg <= div_valid[NS];
            out_valid_reg <= bat_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            in_size_reg <= (s_byte_size > ascm_pkg::SIZE_LIMIT) ?
                           ascm_pkg::SIZE_LIMIT : s_byte_size;
        end
    end

    // Group select, class index and rounding.
    always_comb begin
        cls_word_next      = '0;
        cls_word_next.size = in_size_reg;
        cls_word_next.rem  = ascm_pkg::DIV_SEED;
        cls_word_next.quot = '0;
        if (in_size_reg == '0) begin
            cls_word_next.size_class = '0;
            cls_word_next.rounded    = '0;
        end else if (in_size_reg <= SW'(128)) begin
            cls_word_next.size_class =
                CW'((in_size_reg + SW'(7)) >> 3) - CW'(1);
            cls_word_next.rounded = (in_size_reg + SW'(7)) & ~SW'(7);
        end else if (in_size_reg <= SW'(1024)) begin
            cls_word_next.size_class =
                CW'((in_size_reg - SW'(128) + SW'(15)) >> 4) + CW'(15);
            cls_word_next.rounded = (in_size_reg + SW'(15)) & ~SW'(15);
        end else if (in_size_reg <= SW'(8192)) begin
            cls_word_next.size_class =
                CW'((in_size_reg - SW'(1024) + SW'(127)) >> 7) + CW'(71);
            cls_word_next.rounded = (in_size_reg + SW'(127)) & ~SW'(127);
        end else begin
            cls_word_next.size_class =
                CW'((in_size_reg - SW'(8192) + SW'(1023)) >> 10) + CW'(127);
            cls_word_next.rounded = (in_size_reg + SW'(1023)) & ~SW'(1023);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            cls_word_reg <= cls_word_next;
        end
    end

    assign div_valid[0] = cls_valid_reg;
    assign div_word[0]  = cls_word_reg;

    for (genvar i = 0; i < NS; i++) begin : g_div
        ascm_div_step u_step (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .en        (en),
            .in_valid  (div_valid[i]),
            .in_word   (div_word[i]),
            .out_valid (div_valid[i+1]),
            .out_word  (div_word[i+1])
        );
    end

    // The quotient is only meaningful for sizes 129 to 32768; the clamps cover
    // everything else.
    always_comb begin
        if (div_word[NS].size == '0) begin
            bat_batch_next = '0;
        end else if (div_word[NS].size <= SW'(128)) begin
            bat_batch_next = BW'(512);
        end else if (div_word[NS].size > SW'(32768)) begin
            bat_batch_next = BW'(2);
        end else begin
            bat_batch_next = {{(BW-QW){1'b0}}, div_word[NS].quot};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            bat_size_reg    <= div_word[NS].size;
            bat_class_reg   <= div_word[NS].size_class;
            bat_rounded_reg <= div_word[NS].rounded;
            bat_batch_reg   <= bat_batch_next;
        end
    end

    assign prod       = {{SW{1'b0}}, bat_batch_reg} * {{BW{1'b0}}, bat_size_reg};
    assign pages_full = prod[ascm_pkg::PROD_W-1:ascm_pkg::PAGE_SHIFT];

    always_comb begin
        if (pages_full == '0) begin
            out_pages_next = PW'(1);
        end else if (pages_full > FW'(31)) begin
            out_pages_next = PW'(31);
        end else begin
            out_pages_next = pages_full[PW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_class_reg   <= bat_class_reg;
            out_rounded_reg <= bat_rounded_reg;
            out_batch_reg   <= bat_batch_reg;
            out_pages_reg   <= out_pages_next;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_size_class   = out_class_reg;
    assign m_rounded_size = out_rounded_reg;
    assign m_batch_count  = out_batch_reg;
    assign m_page_count   = out_pages_reg;

`ifndef ASSERT_OFF
    a_class_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_size_class <= 8'd183))
        else $error("size class out of range");

    a_pages_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_page_count != 5'd0))
        else $error("page count is zero");

    a_zero_size: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_batch_count == 10'd0) |->
        (m_rounded_size == 17'd0 && m_size_class == 8'd0))
        else $error("zero batch without zero size");

    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rounded_size)))
        else $error("output word changed under stall");

    a_round_up: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_batch_count != 10'd0) |-> (m_rounded_size != 17'd0))
        else $error("rounded size lost for nonzero request");
`endif

endmodule

`default_nettype wire
